// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define SCFM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scfm assertion failed");

// Clocked assertion that also holds across reset.
`define SCFM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scfm assertion failed");

`endif

// ===== src/scfm_pkg.sv =====
// Shared widths and command codes of the complex FIR magnitude unit.
package scfm_pkg;
    localparam int TAP_W   = 16;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 7;
    localparam int IN_W    = 16;
    localparam int SUM_W   = 38;
    localparam int MAG_W   = 38;
    localparam int HALF_W  = 19;
    localparam int SQ_W    = 76;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;
endpackage

// ===== src/symmetric_complex_fir_magnitude_unit.sv =====
// Top level of the symmetric complex FIR with magnitude output.
// One sample request runs a multiply-accumulate over 2*L terms (one history
// read and one real/imaginary tap pair per cycle through a single complex MAC),
// then pipeline drain, saturation, squaring on one 19x19 multiplier, square root
// and output handoff; a last sample runs this for up to L results.
// Input stays stalled while a request is in work and until its last result is
// taken. History is read as zero beyond the samples seen in the current
// sequence, so ending a sequence needs no clearing pass.
module symmetric_complex_fir_magnitude_unit #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_cmd,
    input  logic [scfm_pkg::IDX_W-1:0]       i_tap_index,
    input  logic signed [scfm_pkg::TAP_W-1:0] i_tap_real,
    input  logic signed [scfm_pkg::TAP_W-1:0] i_tap_imag,
    input  logic signed [scfm_pkg::IN_W-1:0] i_sample,
    input  logic                             i_last_sample,
    input  logic                             i_cfg_we,
    input  logic [scfm_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [scfm_pkg::MAG_W-1:0]       o_magnitude,
    output logic signed [scfm_pkg::SUM_W-1:0] o_real_sum,
    output logic signed [scfm_pkg::SUM_W-1:0] o_imag_sum,
    output logic                             o_end_of_sequence
);
    import scfm_pkg::*;

    localparam int HIST_DEPTH = 2 * MAX_TAPS - 1;
    localparam int HA_W    = $clog2(HIST_DEPTH);
    localparam int CNT_W   = $clog2(HIST_DEPTH + 1);
    localparam int TA_W    = $clog2(MAX_TAPS);
    localparam int LEN_W   = $clog2(MAX_TAPS + 1);
    localparam int K_W     = LEN_W + 1;
    localparam int AGE_W   = LEN_W + 1;
    localparam int AW2     = (AGE_W > HA_W ? AGE_W : HA_W) + 1;
    localparam int PROD_W  = SAMPLE_BITS + TAP_W;
    localparam int ACC_RAW = PROD_W + $clog2(2 * MAX_TAPS);
    localparam int ACC_W   = (ACC_RAW > SUM_W) ? ACC_RAW : SUM_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN =
        {{(ACC_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE, ST_SELECT, ST_MAC, ST_DRAIN, ST_SAT, ST_SQUARE, ST_ROOT, ST_OUT
    } t_state;

    // Storage
    logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
    logic signed [TAP_W-1:0]       tapr_mem [MAX_TAPS];
    logic signed [TAP_W-1:0]       tapi_mem [MAX_TAPS];

    // Control
    t_state              r_state;
    logic [CFG_W-1:0]    r_cfg;
    logic [HA_W-1:0]     r_head;
    logic [CNT_W-1:0]    r_cnt;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_fd;
    logic [LEN_W-1:0]    r_d;
    logic [K_W-1:0]      r_k;
    logic [2:0]          r_sq;
    logic                r_last;
    logic                r_first;
    logic                r_eos;
    logic                r_p1, r_p2, r_v1, r_v2, r_n1, r_n2;
    logic                r_start;
    logic                r_ovalid;

    // Datapath
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [TAP_W-1:0]       r_tr, r_ti;
    logic signed [PROD_W-1:0]      r_pre, r_pim;
    logic signed [ACC_W-1:0]       r_acc_re, r_acc_im;
    logic signed [SUM_W-1:0]       r_re, r_im;
    logic [SQ_W-1:0]               r_nsq;
    logic [MAG_W-1:0]              r_mag;
    logic signed [SUM_W-1:0]       r_ore, r_oim;
    logic                          r_oeos;

    logic                          in_acc;
    logic                          load_we;
    logic                          push;
    logic [LEN_W-1:0]              len_eff;
    logic [HA_W-1:0]               head_nxt;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic [LEN_W-1:0]              j;
    logic                          side;
    logic [AGE_W-1:0]              age_a, age_b, age;
    logic                          term_ok;
    logic [AW2-1:0]                addr_w;
    logic [HA_W-1:0]               rd_addr;
    logic [K_W-1:0]                k_last;
    logic [LEN_W-1:0]              dd;
    logic [SUM_W-1:0]              abs_re, abs_im, abs_sel;
    logic [HALF_W-1:0]             op_a, op_b;
    logic [2*HALF_W-1:0]           sq_prod;
    logic [SQ_W-1:0]               sq_term;
    logic                          sq_done;
    logic [MAG_W-1:0]              sq_root;

    assign in_acc  = i_valid && !o_stall;
    assign load_we = in_acc && (i_cmd == CMD_LOAD) && (int'(i_tap_index) < MAX_TAPS);
    assign push    = in_acc && (i_cmd == CMD_SAMPLE);

    generate
        if (SAMPLE_BITS > IN_W) begin : g_wide
            assign x_in = {{(SAMPLE_BITS-IN_W){1'b0}}, i_sample};
        end else begin : g_narrow
            assign x_in = i_sample[SAMPLE_BITS-1:0];
        end
    endgenerate

    always_comb begin
        if (r_cfg == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(r_cfg) > MAX_TAPS) begin
            len_eff = LEN_W'(MAX_TAPS);
        end else begin
            len_eff = LEN_W'(r_cfg);
        end
    end

    assign head_nxt = (r_head == HA_W'(HIST_DEPTH - 1)) ? '0 : r_head + HA_W'(1);

    // Term k covers tap j = k/2: even k reaches back, odd k reaches ahead.
    assign j     = r_k[K_W-1:1];
    assign side  = r_k[0];
    assign age_a = AGE_W'(r_d) + AGE_W'(j);
    assign age_b = AGE_W'(r_d) - AGE_W'(j);
    assign age   = side ? age_b : age_a;
    assign term_ok = side ? ((j != '0) && (j <= r_d) && (int'(age_b) < int'(r_cnt)))
                          : (int'(age_a) < int'(r_cnt));

    always_comb begin
        addr_w = AW2'(r_head) - AW2'(age);
        if (int'(age) > int'(r_head)) begin
            addr_w = addr_w + AW2'(HIST_DEPTH);
        end
    end
    assign rd_addr = addr_w[HA_W-1:0];
    assign k_last  = {r_len, 1'b0} - K_W'(1);
    assign dd      = r_fd - LEN_W'(1);

    // Memories
    always_ff @(posedge i_clk) begin
        if (push) begin
            hist_mem[head_nxt] <= x_in;
        end
        r_x <= hist_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            tapr_mem[TA_W'(i_tap_index)] <= i_tap_real;
            tapi_mem[TA_W'(i_tap_index)] <= i_tap_imag;
        end
        r_tr <= tapr_mem[j[TA_W-1:0]];
        r_ti <= tapi_mem[j[TA_W-1:0]];
    end

    // Squaring operands: a^2 = ah^2<<38 + ah*al<<20 + al^2, real then imaginary.
    assign abs_re  = r_re[SUM_W-1] ? SUM_W'(-r_re) : SUM_W'(r_re);
    assign abs_im  = r_im[SUM_W-1] ? SUM_W'(-r_im) : SUM_W'(r_im);
    assign abs_sel = (r_sq < 3'd3) ? abs_re : abs_im;

    always_comb begin
        case (r_sq)
            3'd0, 3'd3: begin
                op_a = abs_sel[SUM_W-1:HALF_W];
                op_b = abs_sel[SUM_W-1:HALF_W];
            end
            3'd1, 3'd4: begin
                op_a = abs_sel[SUM_W-1:HALF_W];
                op_b = abs_sel[HALF_W-1:0];
            end
            default: begin
                op_a = abs_sel[HALF_W-1:0];
                op_b = abs_sel[HALF_W-1:0];
            end
        endcase
    end
    assign sq_prod = op_a * op_b;

    always_comb begin
        case (r_sq)
            3'd0, 3'd3: sq_term = {sq_prod, {(2*HALF_W){1'b0}}};
            3'd1, 3'd4: sq_term = {{(HALF_W-1){1'b0}}, sq_prod, {(HALF_W+1){1'b0}}};
            default:    sq_term = {{(2*HALF_W){1'b0}}, sq_prod};
        endcase
    end

    scfm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_radicand (r_nsq),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cfg    <= CFG_W'(1);
            r_head   <= '0;
            r_cnt    <= '0;
            r_first  <= 1'b0;
            r_last   <= 1'b0;
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_start <= 1'b0;
            r_p1    <= (r_state == ST_MAC);
            r_v1    <= term_ok;
            r_n1    <= side;
            r_p2    <= r_p1;
            r_v2    <= r_v1;
            r_n2    <= r_n1;
            r_pre   <= r_x * r_tr;
            r_pim   <= r_x * r_ti;
            if (r_p2 && r_v2) begin
                r_acc_re <= r_acc_re + {{(ACC_W-PROD_W){r_pre[PROD_W-1]}}, r_pre};
                if (r_n2) begin
                    r_acc_im <= r_acc_im - {{(ACC_W-PROD_W){r_pim[PROD_W-1]}}, r_pim};
                end else begin
                    r_acc_im <= r_acc_im + {{(ACC_W-PROD_W){r_pim[PROD_W-1]}}, r_pim};
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (push) begin
                        r_head  <= head_nxt;
                        if (r_cnt != CNT_W'(HIST_DEPTH)) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        r_len   <= len_eff;
                        r_fd    <= len_eff - LEN_W'(1);
                        r_last  <= i_last_sample;
                        r_first <= 1'b1;
                        r_state <= ST_SELECT;
                    end
                end
                ST_SELECT: begin
                    r_k      <= '0;
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                    if (r_first) begin
                        r_first <= 1'b0;
                        if (int'(r_cnt) >= int'(r_len)) begin
                            r_d     <= r_len - LEN_W'(1);
                            r_eos   <= r_last && (r_len == LEN_W'(1));
                            r_state <= ST_MAC;
                        end
                    end else if (r_last && (r_fd != '0)) begin
                        // Flush one trailing position; skip those with no samples.
                        r_fd <= dd;
                        if (int'(dd) < int'(r_cnt)) begin
                            r_d     <= dd;
                            r_eos   <= (dd == '0);
                            r_state <= ST_MAC;
                        end
                    end else begin
                        if (r_last) begin
                            r_cnt <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_MAC: begin
                    r_k <= r_k + K_W'(1);
                    if (r_k == k_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_p1 && !r_p2) begin
                        r_state <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    if (r_acc_re > ACC_MAX) begin
                        r_re <= ACC_MAX[SUM_W-1:0];
                    end else if (r_acc_re < ACC_MIN) begin
                        r_re <= ACC_MIN[SUM_W-1:0];
                    end else begin
                        r_re <= r_acc_re[SUM_W-1:0];
                    end
                    if (r_acc_im > ACC_MAX) begin
                        r_im <= ACC_MAX[SUM_W-1:0];
                    end else if (r_acc_im < ACC_MIN) begin
                        r_im <= ACC_MIN[SUM_W-1:0];
                    end else begin
                        r_im <= r_acc_im[SUM_W-1:0];
                    end
                    r_sq    <= '0;
                    r_nsq   <= '0;
                    r_state <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    r_nsq <= r_nsq + sq_term;
                    r_sq  <= r_sq + 3'd1;
                    if (r_sq == 3'd5) begin
                        r_start <= 1'b1;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sq_done) begin
                        r_mag    <= sq_root;
                        r_ore    <= r_re;
                        r_oim    <= r_im;
                        r_oeos   <= r_eos;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_state  <= ST_SELECT;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall           = (r_state != ST_IDLE);
    assign o_valid           = r_ovalid;
    assign o_magnitude       = r_mag;
    assign o_real_sum        = r_ore;
    assign o_imag_sum        = r_oim;
    assign o_end_of_sequence = r_oeos;
endmodule

// ===== src/scfm_isqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
module scfm_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [scfm_pkg::SQ_W-1:0]   i_radicand,
    output logic                        o_done,
    output logic [scfm_pkg::MAG_W-1:0]  o_root
);
    import scfm_pkg::*;

    localparam int REM_W = MAG_W + 3;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [REM_W-1:0] r_rem;
    logic [MAG_W-1:0] r_root;
    logic [SQ_W-1:0]  r_rad;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[SQ_W-1:SQ_W-2]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= i_radicand;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[SQ_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[MAG_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== src/scfm_checker.sv =====
// Port-level checks of the complex FIR magnitude unit, bound to the top level.
`include "assert_macros.svh"

module scfm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [scfm_pkg::MAG_W-1:0]         o_magnitude,
    input logic signed [scfm_pkg::SUM_W-1:0]  o_real_sum,
    input logic signed [scfm_pkg::SUM_W-1:0]  o_imag_sum
);
    import scfm_pkg::*;

    logic [SUM_W-1:0]             abs_re;
    logic [SUM_W-1:0]             abs_im;
    logic [MAG_W+2*SUM_W-1:0]     payload;

    assign abs_re  = o_real_sum[SUM_W-1] ? SUM_W'(-o_real_sum) : SUM_W'(o_real_sum);
    assign abs_im  = o_imag_sum[SUM_W-1] ? SUM_W'(-o_imag_sum) : SUM_W'(o_imag_sum);
    assign payload = {o_magnitude, o_real_sum, o_imag_sum};

    `SCFM_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_valid)
    `SCFM_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(payload))
    `SCFM_ASSERT(a_busy_while_result, i_clk, i_rst_n, o_valid |-> o_stall)
    `SCFM_ASSERT(a_mag_ge_real, i_clk, i_rst_n, o_valid |-> o_magnitude >= abs_re)
    `SCFM_ASSERT(a_mag_ge_imag, i_clk, i_rst_n, o_valid |-> o_magnitude >= abs_im)
endmodule

bind symmetric_complex_fir_magnitude_unit scfm_checker u_scfm_checker (.*);
